### rtl/cdt_pkg.sv
// Shared types and constants of the countdown timer with alarm.
// Used by the control stage, the display pipeline and the top level; no dependencies.
`default_nettype none

package cdt_pkg;

  localparam int TICK_W     = 23;
  localparam int ALARM_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ON_TICKS = 2'd2;

  localparam logic [TICK_W-1:0]  TOTAL_TICKS_RESET    = 23'd0;
  localparam logic [ALARM_W-1:0] ALARM_PERIOD_RESET   = 9'd140;
  localparam logic [ALARM_W-1:0] ALARM_ON_TICKS_RESET = 9'd70;

  localparam logic [TICK_W-1:0] ALARM_WRAP = 23'd280;
  localparam logic [4:0]        SHOW_MASK  = 5'h1F;
  localparam logic [2:0]        QUIT_MASK  = 3'h7;

  // Reciprocals for division by constants; each estimate is at most one low.
  localparam logic [23:0] RECIP_100   = 24'd10737418;  // floor(2^30 / 100)
  localparam logic [17:0] RECIP_60    = 18'd139810;    // floor(2^23 / 60)
  localparam logic [12:0] RECIP_100_S = 13'd5243;      // 2^-19 scale, exact below 2000

  typedef struct packed {
    logic [TICK_W-1:0]  total_ticks;
    logic [ALARM_W-1:0] alarm_period;
    logic [ALARM_W-1:0] alarm_on_ticks;
  } cfg_t;

  // What the control stage hands to the display pipeline for one item.
  typedef struct packed {
    logic               show;
    logic [TICK_W-1:0]  remaining;
    logic               buzz_en;
    logic [ALARM_W-1:0] alarm_cnt;
    logic               finished;
  } tick_rec_t;

  // Two decimal digits {tens, ones} for values below 100.
  typedef logic [7:0] dec2_tab_t [128];

  function automatic dec2_tab_t build_dec2();
    dec2_tab_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = 8'h00;
    end
    for (int tens = 0; tens < 10; tens++) begin
      for (int ones = 0; ones < 10; ones++) begin
        t[tens * 10 + ones] = {4'(tens), 4'(ones)};
      end
    end
    return t;
  endfunction

  localparam dec2_tab_t DEC2 = build_dec2();

endpackage

`default_nettype wire

### rtl/cdt_in_if.sv
// Tick channel of the countdown timer: valid, ready and the quit key flag.
// No dependencies.
`default_nettype none

interface cdt_in_if;
  logic valid;
  logic ready;
  logic quit_key;

  modport source (output valid, output quit_key, input ready);
  modport sink (input valid, input quit_key, output ready);
endinterface

`default_nettype wire

### rtl/cdt_out_if.sv
// Result channel of the countdown timer: valid, ready and the display and buzzer fields.
// No dependencies.
`default_nettype none

interface cdt_out_if;
  logic       valid;
  logic       ready;
  logic       show_valid;
  logic       minute_thousands;
  logic [3:0] minute_hundreds;
  logic [3:0] minute_tens;
  logic [3:0] minute_ones;
  logic [2:0] second_tens;
  logic [3:0] second_ones;
  logic [3:0] char_count;
  logic       expired;
  logic       buzzer_on;
  logic       finished;

  modport source (
    output valid, output show_valid, output minute_thousands, output minute_hundreds,
    output minute_tens, output minute_ones, output second_tens, output second_ones,
    output char_count, output expired, output buzzer_on, output finished,
    input ready
  );
  modport sink (
    input valid, input show_valid, input minute_thousands, input minute_hundreds,
    input minute_tens, input minute_ones, input second_tens, input second_ones,
    input char_count, input expired, input buzzer_on, input finished,
    output ready
  );
endinterface

`default_nettype wire

### rtl/countdown_timer_with_alarm.sv
// Countdown timer with alarm: one item per 10 ms tick, one result item per tick.
// Registers from acceptance to the port: control record, stages s1 to s5, result. One item
// is accepted every cycle unless stalled, the seven registered stages (state, two division
// steps, digit split, result register) moving independently under back-pressure.
// Synchronous reset clears the phase to counting, the count to zero, the pipeline and the
// registers to 0, 140 and 70. Depends on cdt_pkg, cdt_in_if, cdt_out_if, cdt_ctrl, cdt_pipe.
`default_nettype none

module countdown_timer_with_alarm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdt_pkg::CFG_DATA_W-1:0] cfg_data,
  cdt_in_if.sink                         tick,
  cdt_out_if.source                      result
);

  cdt_pkg::cfg_t      cfg;
  cdt_pkg::tick_rec_t rec;
  logic               rec_valid;
  logic               rec_ready;

  cdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  cdt_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .result    (result)
  );

endmodule

`default_nettype wire

### rtl/cdt_ctrl.sv
// Configuration registers, tick counter and phase state machine of the timer.
// Depends on cdt_pkg and cdt_in_if.
`default_nettype none

module cdt_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cdt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cdt_pkg::CFG_DATA_W-1:0]   cfg_data,
  cdt_in_if.sink                           tick,
  output cdt_pkg::cfg_t                    cfg,
  output logic                             rec_valid,
  input  logic                             rec_ready,
  output cdt_pkg::tick_rec_t               rec
);

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_ALARM,
    PH_STOP
  } phase_t;

  phase_t                       phase, phase_next, cur_phase;
  logic [cdt_pkg::TICK_W-1:0]   tick_count, tick_count_next, cur_count, inc;
  cdt_pkg::tick_rec_t           rec_next;
  logic                         accept, quit_hit;

  assign tick.ready = !rec_valid || rec_ready;
  assign accept     = tick.valid && tick.ready;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    rec_next        = '0;
    cur_phase       = phase;
    cur_count       = tick_count;
    quit_hit        = 1'b0;
    // A count already at or past the total goes straight into the alarm.
    if (phase == PH_COUNT && tick_count >= cfg.total_ticks) begin
      cur_phase = PH_ALARM;
      cur_count = '0;
    end
    inc = cur_count + 23'd1;
    unique case (cur_phase)
      PH_COUNT: begin
        rec_next.show      = (inc[4:0] & cdt_pkg::SHOW_MASK) == 5'd0;
        rec_next.remaining = cfg.total_ticks - inc;
        quit_hit           = ((inc[2:0] & cdt_pkg::QUIT_MASK) == 3'd0) && tick.quit_key;
        if (quit_hit) begin
          phase_next        = PH_STOP;
          tick_count_next   = inc;
          rec_next.finished = 1'b1;
        end else if (inc >= cfg.total_ticks) begin
          phase_next      = PH_ALARM;
          tick_count_next = '0;
        end else begin
          phase_next      = PH_COUNT;
          tick_count_next = inc;
        end
      end
      PH_ALARM: begin
        if (inc >= cdt_pkg::ALARM_WRAP) begin
          tick_count_next = '0;
        end else begin
          tick_count_next = inc;
        end
        rec_next.alarm_cnt = tick_count_next[cdt_pkg::ALARM_W-1:0];
        quit_hit = ((tick_count_next[2:0] & cdt_pkg::QUIT_MASK) == 3'd0) && tick.quit_key;
        if (quit_hit) begin
          phase_next        = PH_STOP;
          rec_next.finished = 1'b1;
        end else begin
          phase_next       = PH_ALARM;
          rec_next.buzz_en = 1'b1;
        end
      end
      default: begin
        rec_next.finished = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_COUNT;
      tick_count         <= '0;
      rec_valid          <= 1'b0;
      cfg.total_ticks    <= cdt_pkg::TOTAL_TICKS_RESET;
      cfg.alarm_period   <= cdt_pkg::ALARM_PERIOD_RESET;
      cfg.alarm_on_ticks <= cdt_pkg::ALARM_ON_TICKS_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cdt_pkg::REG_TOTAL_TICKS:    cfg.total_ticks    <= cfg_data;
          cdt_pkg::REG_ALARM_PERIOD:   cfg.alarm_period   <= cfg_data[cdt_pkg::ALARM_W-1:0];
          cdt_pkg::REG_ALARM_ON_TICKS: cfg.alarm_on_ticks <= cfg_data[cdt_pkg::ALARM_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        rec_valid  <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
    if (accept) begin
      rec <= rec_next;
    end
  end

endmodule

`default_nettype wire

### rtl/cdt_pipe.sv
// Display and buzzer pipeline: remaining ticks to minute and second digits,
// alarm count modulo the period, and the result register. Depends on cdt_pkg and cdt_out_if.
`default_nettype none

module cdt_pipe (
  input  logic               clk,
  input  logic               rst,
  input  cdt_pkg::cfg_t      cfg,
  input  logic               rec_valid,
  output logic               rec_ready,
  input  cdt_pkg::tick_rec_t rec,
  cdt_out_if.source          result
);

  typedef struct packed {
    logic        show;
    logic        finished;
    logic        buzz_en;
    logic [46:0] prod;
    logic [22:0] remaining;
    logic [8:0]  mod_part;
    logic [3:0]  cnt_low;
  } s1_t;

  typedef struct packed {
    logic        show;
    logic        finished;
    logic        buzz;
    logic [16:0] secs;
  } s2_t;

  typedef struct packed {
    logic        show;
    logic        finished;
    logic        buzz;
    logic        expired;
    logic [16:0] secs;
    logic [34:0] prod;
  } s3_t;

  typedef struct packed {
    logic        show;
    logic        finished;
    logic        buzz;
    logic        expired;
    logic [10:0] minutes;
    logic [5:0]  seconds;
  } s4_t;

  typedef struct packed {
    logic        show;
    logic        finished;
    logic        buzz;
    logic        expired;
    logic [10:0] minutes;
    logic [4:0]  hundreds;
    logic [7:0]  sec_digits;
    logic [3:0]  char_count;
  } s5_t;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  logic [8:0]  period;
  logic [8:0]  m1, m2;
  logic [23:0] rem100;
  logic [16:0] q_est;
  logic [10:0] min_est;
  logic [16:0] rem60;
  logic [23:0] prod5;
  logic        th;
  logic [3:0]  hund;
  logic [10:0] below100;
  logic [7:0]  min_digits;

  // One restoring step of the remainder by the alarm period.
  function automatic logic [8:0] mod_step(input logic [8:0] r, input logic b,
                                          input logic [8:0] p);
    logic [9:0] t;
    t = {r, b};
    if (t >= {1'b0, p}) begin
      t = t - {1'b0, p};
    end
    return t[8:0];
  endfunction

  assign period = (cfg.alarm_period == 9'd0) ? 9'd1 : cfg.alarm_period;

  assign rdy6      = !result.valid || result.ready;
  assign rdy5      = !v5 || rdy6;
  assign rdy4      = !v4 || rdy5;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign rec_ready = rdy1;

  always_comb begin
    m1 = 9'd0;
    for (int i = 8; i >= 4; i--) begin
      m1 = mod_step(m1, rec.alarm_cnt[i], period);
    end
    s1_next.show      = rec.show;
    s1_next.finished  = rec.finished;
    s1_next.buzz_en   = rec.buzz_en;
    s1_next.prod      = 47'(rec.remaining) * 47'(cdt_pkg::RECIP_100);
    s1_next.remaining = rec.remaining;
    s1_next.mod_part  = m1;
    s1_next.cnt_low   = rec.alarm_cnt[3:0];
  end

  always_comb begin
    m2 = s1.mod_part;
    for (int i = 3; i >= 0; i--) begin
      m2 = mod_step(m2, s1.cnt_low[i], period);
    end
    q_est  = s1.prod[46:30];
    rem100 = {1'b0, s1.remaining} - (24'(q_est) * 24'd100);
    s2_next.show     = s1.show;
    s2_next.finished = s1.finished;
    s2_next.buzz     = s1.buzz_en && (m2 < cfg.alarm_on_ticks);
    s2_next.secs     = q_est + 17'(rem100 >= 24'd100);
  end

  always_comb begin
    s3_next.show     = s2.show;
    s3_next.finished = s2.finished;
    s3_next.buzz     = s2.buzz;
    s3_next.expired  = s2.secs == 17'd0;
    s3_next.secs     = s2.secs;
    s3_next.prod     = 35'(s2.secs) * 35'(cdt_pkg::RECIP_60);
  end

  always_comb begin
    min_est = s3.prod[33:23];
    rem60   = s3.secs - (17'(min_est) * 17'd60);
    s4_next.show     = s3.show;
    s4_next.finished = s3.finished;
    s4_next.buzz     = s3.buzz;
    s4_next.expired  = s3.expired;
    if (rem60 >= 17'd60) begin
      s4_next.minutes = min_est + 11'd1;
      s4_next.seconds = 6'(rem60 - 17'd60);
    end else begin
      s4_next.minutes = min_est;
      s4_next.seconds = rem60[5:0];
    end
  end

  always_comb begin
    prod5 = 24'(s4.minutes) * 24'(cdt_pkg::RECIP_100_S);
    s5_next.show       = s4.show;
    s5_next.finished   = s4.finished;
    s5_next.buzz       = s4.buzz;
    s5_next.expired    = s4.expired;
    s5_next.minutes    = s4.minutes;
    s5_next.hundreds   = prod5[23:19];
    s5_next.sec_digits = cdt_pkg::DEC2[{1'b0, s4.seconds}];
    s5_next.char_count = 4'd9 + 4'(s4.minutes >= 11'd100) + 4'(s4.minutes >= 11'd1000);
  end

  always_comb begin
    th         = s5.hundreds >= 5'd10;
    hund       = th ? 4'(s5.hundreds - 5'd10) : s5.hundreds[3:0];
    below100   = s5.minutes - (11'(s5.hundreds) * 11'd100);
    min_digits = cdt_pkg::DEC2[below100[6:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= rec_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) result.valid <= v5;
    end
    if (rdy1) s1 <= s1_next;
    if (rdy2) s2 <= s2_next;
    if (rdy3) s3 <= s3_next;
    if (rdy4) s4 <= s4_next;
    if (rdy5) s5 <= s5_next;
    if (rdy6) begin
      result.buzzer_on  <= s5.buzz;
      result.finished   <= s5.finished;
      result.show_valid <= s5.show;
      if (s5.show) begin
        result.minute_thousands <= th;
        result.minute_hundreds  <= hund;
        result.minute_tens      <= min_digits[7:4];
        result.minute_ones      <= min_digits[3:0];
        result.second_tens      <= s5.sec_digits[6:4];
        result.second_ones      <= s5.sec_digits[3:0];
        result.char_count       <= s5.char_count;
        result.expired          <= s5.expired;
      end else begin
        result.minute_thousands <= 1'b0;
        result.minute_hundreds  <= 4'd0;
        result.minute_tens      <= 4'd0;
        result.minute_ones      <= 4'd0;
        result.second_tens      <= 3'd0;
        result.second_ones      <= 4'd0;
        result.char_count       <= 4'd0;
        result.expired          <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
